FILE: rtl/bblc_pkg.sv
package bblc_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int TAG_BITS_DEF = 32;
  localparam int REQ_W   = 3;
  localparam int KEY_W   = 32;
  localparam int BYTES_W = 48;
  localparam int EVC_W   = 5;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TRIM   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RSTAT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXB   = 1'd1;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   key_tag;
    logic [BYTES_W-1:0] entry_bytes;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               stored;
    logic [EVC_W-1:0]   evicted_count;
    logic [BYTES_W-1:0] used_bytes_now;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
  } rsp_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE, OP_LOOKUP, OP_STORE, OP_CLEAR, OP_TRIM, OP_WIPE, OP_RSTAT, OP_MISS
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
  } cmd_t;

endpackage

FILE: rtl/bblc_front.sv
module bblc_front #(
  parameter int TAG_BITS = bblc_pkg::TAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  bblc_pkg::req_t     req,
  input  logic               enabled,
  input  logic [bblc_pkg::BYTES_W-1:0] max_bytes,
  output logic               cmd_valid,
  output bblc_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);
  localparam int KW = bblc_pkg::KEY_W;
  logic [KW-1:0] mask;
  logic active;
  bblc_pkg::cmd_t c;

  // two-entry queue
  bblc_pkg::cmd_t q [2];
  logic [1:0] fill;

  always_comb begin
    mask = (TAG_BITS >= KW) ? {KW{1'b1}} : KW'((64'd1 << TAG_BITS) - 64'd1);
    active = enabled && (max_bytes != '0);
    c.tag = req.key_tag & mask;
    c.bytes = req.entry_bytes;
    case (req.req_type)
      bblc_pkg::REQ_LOOKUP: c.op = active ? bblc_pkg::OP_LOOKUP : bblc_pkg::OP_MISS;
      bblc_pkg::REQ_STORE:
        c.op = (active && req.entry_bytes != '0 && req.entry_bytes <= max_bytes)
               ? bblc_pkg::OP_STORE : bblc_pkg::OP_NONE;
      bblc_pkg::REQ_CLEAR: c.op = bblc_pkg::OP_CLEAR;
      bblc_pkg::REQ_TRIM:
        c.op = !enabled ? bblc_pkg::OP_CLEAR
             : (max_bytes == '0 ? bblc_pkg::OP_NONE : bblc_pkg::OP_TRIM);
      bblc_pkg::REQ_RSTAT: c.op = bblc_pkg::OP_RSTAT;
      default: c.op = bblc_pkg::OP_NONE;
    endcase
  end

  assign cmd_valid = (fill != 2'd0);
  assign cmd = q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, take} - {1'b0, cmd_pop};
    end
    // take never coincides with a full queue
    if (cmd_pop) begin
      if (fill == 2'd2) q[0] <= q[1];
      else if (take) q[0] <= c;
    end else if (take) begin
      q[fill[0]] <= c;
    end
  end
endmodule

FILE: rtl/bblc_back.sv
module bblc_back #(
  parameter int ENTRIES = bblc_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  bblc_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic [bblc_pkg::BYTES_W-1:0] max_bytes,
  output logic           done,
  output bblc_pkg::rsp_t rsp
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW = bblc_pkg::BYTES_W;
  localparam int KW = bblc_pkg::KEY_W;
  localparam int EW = bblc_pkg::EVC_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_EVICT = 6'b000100,
    S_FULL = 6'b001000, S_INS = 6'b010000, S_DONE = 6'b100000
  } st_t;
  st_t st;

  logic [ENTRIES-1:0] vld;
  logic [KW-1:0] tagr [ENTRIES];
  logic [BW-1:0] sizer [ENTRIES];
  logic [IW-1:0] rank [ENTRIES];
  logic [IW:0] nvld;
  logic [BW-1:0] used;
  logic [bblc_pkg::CNT_W-1:0] hits, misses;
  bblc_pkg::cmd_t cur;
  logic [EW-1:0] evc;
  logic hitf, storedf;

  // parallel per-slot match and oldest search (one level of compare)
  logic [ENTRIES-1:0] match;
  logic [IW-1:0] mslot, oslot, fslot;
  logic mfound, ofound, ffound, full;
  logic [BW:0] need;

  always_comb begin
    mfound = 1'b0; mslot = '0; ofound = 1'b0; oslot = '0; ffound = 1'b0; fslot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = vld[i] && tagr[i] == cur.tag;
      if (match[i]) begin mfound = 1'b1; mslot = IW'(i); end
      // oldest valid slot holds rank count-1
      if (vld[i] && {1'b0, rank[i]} == nvld - 1'b1) begin
        ofound = 1'b1; oslot = IW'(i);
      end
    end
    for (int i = ENTRIES-1; i >= 0; i--)
      if (!vld[i]) begin ffound = 1'b1; fslot = IW'(i); end
    full = &vld;
    need = {1'b0, used} + {1'b0, (st == S_EVICT && cur.op == bblc_pkg::OP_TRIM)
                                  ? BW'(0) : cur.bytes};
  end

  assign cmd_pop = (st == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; vld <= '0; nvld <= '0; used <= '0; hits <= '0; misses <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: if (cmd_valid) begin
          cur <= cmd; evc <= '0; hitf <= 1'b0; storedf <= 1'b0;
          case (cmd.op)
            bblc_pkg::OP_LOOKUP, bblc_pkg::OP_STORE: st <= S_SCAN;
            bblc_pkg::OP_TRIM: st <= S_EVICT;
            bblc_pkg::OP_CLEAR: begin
              vld <= '0; nvld <= '0; used <= '0; st <= S_DONE;
            end
            bblc_pkg::OP_RSTAT: begin hits <= '0; misses <= '0; st <= S_DONE; end
            bblc_pkg::OP_MISS: begin misses <= misses + 1'b1; st <= S_DONE; end
            default: st <= S_DONE;
          endcase
        end
        S_SCAN: begin
          if (cur.op == bblc_pkg::OP_LOOKUP) begin
            if (mfound) begin
              for (int i = 0; i < ENTRIES; i++)
                if (vld[i] && rank[i] < rank[mslot]) rank[i] <= rank[i] + 1'b1;
              rank[mslot] <= '0;
              hits <= hits + 1'b1; hitf <= 1'b1;
            end else misses <= misses + 1'b1;
            st <= S_DONE;
          end else begin
            if (mfound) begin
              vld[mslot] <= 1'b0;
              nvld <= nvld - 1'b1;
              used <= used - sizer[mslot];
              for (int i = 0; i < ENTRIES; i++)
                if (vld[i] && rank[i] > rank[mslot]) rank[i] <= rank[i] - 1'b1;
            end
            st <= S_EVICT;
          end
        end
        S_EVICT: begin
          // one eviction per cycle
          if (need > {1'b0, max_bytes} && ofound) begin
            vld[oslot] <= 1'b0;
            nvld <= nvld - 1'b1;
            used <= used - sizer[oslot];
            if (evc != '1) evc <= evc + 1'b1;
          end else st <= (cur.op == bblc_pkg::OP_STORE) ? S_FULL : S_DONE;
        end
        S_FULL: begin
          if (full) begin
            vld[oslot] <= 1'b0;
            nvld <= nvld - 1'b1;
            used <= used - sizer[oslot];
            if (evc != '1) evc <= evc + 1'b1;
          end
          st <= S_INS;
        end
        S_INS: begin
          for (int i = 0; i < ENTRIES; i++)
            if (vld[i]) rank[i] <= rank[i] + 1'b1;
          if (ffound) begin
            vld[fslot] <= 1'b1; tagr[fslot] <= cur.tag; sizer[fslot] <= cur.bytes;
            rank[fslot] <= '0; used <= used + cur.bytes; storedf <= 1'b1;
            nvld <= nvld + 1'b1;
          end
          st <= S_DONE;
        end
        S_DONE: begin done <= 1'b1; st <= S_IDLE; end
        default: st <= S_IDLE;
      endcase
    end
  end

  // ranks of evicted oldest need no shift: it holds the top rank
  always_comb begin
    rsp.hit = hitf;
    rsp.stored = storedf;
    rsp.evicted_count = evc;
    rsp.used_bytes_now = used;
    rsp.hit_total = hits;
    rsp.miss_total = misses;
  end
endmodule

FILE: rtl/byte_budget_lru_cache.sv
// Byte-budget LRU cache directory. Issue an item with start while busy is low;
// exactly one result appears later for one cycle with done high and cannot be
// held off, so capture it then. A front stage classifies each item against the
// current configuration and queues it (two deep); a back sequencer updates the
// table. A lookup runs scan then done in the back (only done while caching is
// inactive); a store runs scan, evict (repeated while entries are evicted for
// space), full, insert and done (an ignored store only done); a trim runs evict
// (repeated while evicting) then done (only done if disabled or budget is zero);
// other items only done. An item queued behind another also waits for it. busy
// is high while the queue is full. Write configuration only when idle.
module byte_budget_lru_cache #(
  parameter int ENTRIES  = bblc_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = bblc_pkg::TAG_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  bblc_pkg::req_t req,
  output logic done,
  output bblc_pkg::rsp_t rsp,
  input  logic cfg_we,
  input  logic [bblc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bblc_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic enabled;
  logic [bblc_pkg::BYTES_W-1:0] max_bytes;
  logic cmd_valid, cmd_pop, q_full;
  bblc_pkg::cmd_t cmd;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1; max_bytes <= '0; cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, start && !busy} - {1'b0, cmd_pop};
      if (cfg_we) begin
        case (cfg_index)
          bblc_pkg::CFG_ENABLE: enabled <= cfg_data[0];
          bblc_pkg::CFG_MAXB:   max_bytes <= cfg_data;
          default: ;
        endcase
      end
    end
  end
  assign q_full = (cnt == 2'd2);
  assign busy = q_full;

  bblc_front #(.TAG_BITS(TAG_BITS)) u_front (
    .clk, .rst, .take(start && !busy), .req, .enabled, .max_bytes,
    .cmd_valid, .cmd, .cmd_pop);

  bblc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .max_bytes, .done, .rsp);
endmodule

FILE: rtl/bblc_checker.sv
module bblc_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input bblc_pkg::rsp_t rsp
);
  a_hit_not_stored: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.hit && rsp.stored)) else $error("hit and stored together");
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back results");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.hit) |-> rsp.evicted_count == '0) else $error("hit evicted");
  a_rst_idle: assert property (@(posedge clk) $past(rst) |-> !done && !busy)
    else $error("activity after reset");
endmodule

bind byte_budget_lru_cache bblc_checker u_chk (
  .clk, .rst, .busy, .done, .rsp);
